[hw/rtl/assert_macros.svh]
// Assertion macros used by clock_page_replacement.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hw/rtl/cpr_pkg.sv]
// Shared types, widths and defaults for the clock page replacement block.
package cpr_pkg;

    localparam int PAGES_DEF           = 65536;
    localparam int FRAMES_DEF          = 64;
    localparam int MAX_OFFSET_BITS_DEF = 12;

    localparam int PAGE_NUMBER_W   = 16;
    localparam int PAGE_OFFSET_W   = 12;
    localparam int FRAME_W         = 6;
    localparam int PADDR_W         = 18;
    localparam int CFG_DATA_W      = 7;
    localparam int CFG_INDEX_W     = 2;
    localparam int OFFSET_BITS_W   = 4;

    localparam int FRAMES_IN_USE_RST = 64;
    localparam int OFFSET_BITS_RST   = 12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAMES_IN_USE = 2'd0,
        CFG_OFFSET_BITS   = 2'd1
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD_MUL,
        S_MOD_SUB,
        S_MAP_RD,
        S_OWN_RD,
        S_DECIDE,
        S_SWEEP
    } state_t;

endpackage

[hw/rtl/clock_page_replacement.sv]
// Clock (second-chance) page replacement unit: page map, frame table and clock hand.
// A hit or free-frame fill runs MOD_MUL, MOD_SUB, MAP_RD, OWN_RD and DECIDE before its
// result strobe; busy drops in that cycle and the next request may follow at once.
// A full-table fault then enters SWEEP: the hand clears each set use bit it meets (at most
// frames_in_use) and takes the first clear one; serial RAM reads set the cost; no stall.
// Reset is asynchronous: frames_in_use 64, offset_bits 12, table fill count and hand zero.
`include "assert_macros.svh"

module clock_page_replacement #(
    parameter int PAGES           = cpr_pkg::PAGES_DEF,
    parameter int FRAMES          = cpr_pkg::FRAMES_DEF,
    parameter int MAX_OFFSET_BITS = cpr_pkg::MAX_OFFSET_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [cpr_pkg::PAGE_NUMBER_W-1:0] page_number,
    input  logic [cpr_pkg::PAGE_OFFSET_W-1:0] page_offset,
    output logic                              done,
    output logic [cpr_pkg::FRAME_W-1:0]       frame,
    output logic                              hit,
    output logic [cpr_pkg::PADDR_W-1:0]       physical_address,
    input  logic                              cfg_write,
    input  logic [cpr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cpr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PN_W     = cpr_pkg::PAGE_NUMBER_W;
    localparam int PO_W     = cpr_pkg::PAGE_OFFSET_W;
    localparam int FRAME_W  = cpr_pkg::FRAME_W;
    localparam int PADDR_W  = cpr_pkg::PADDR_W;
    localparam int OB_W     = cpr_pkg::OFFSET_BITS_W;
    localparam int FW       = $clog2(FRAMES);
    localparam int FCNT_W   = $clog2(FRAMES + 1);
    localparam int PAGE_W   = $clog2(PAGES);
    localparam int OWN_W    = PAGE_W + 1;
    localparam int PROD_W   = PN_W + 32;
    localparam int REM_W    = PN_W + 1;
    localparam bit WRAP     = PAGES < (1 << PN_W);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / PAGES);
    localparam int FRAMES_RST = (cpr_pkg::FRAMES_IN_USE_RST > FRAMES) ?
                                FRAMES : cpr_pkg::FRAMES_IN_USE_RST;
    localparam int OB_RST     = (cpr_pkg::OFFSET_BITS_RST > MAX_OFFSET_BITS) ?
                                MAX_OFFSET_BITS : cpr_pkg::OFFSET_BITS_RST;

    cpr_pkg::state_t state_reg, state_next;

    logic [FCNT_W-1:0] frames_reg, frames_next;
    logic [OB_W-1:0]   offset_bits_reg, offset_bits_next;
    logic [FCNT_W-1:0] fill_reg, fill_next;
    logic [FW-1:0]     hand_reg, hand_next;
    logic              done_reg, done_next;

    logic [PN_W-1:0]    pn_reg, pn_next;
    logic [PO_W-1:0]    off_reg, off_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [PAGE_W-1:0]  page_reg, page_next;
    logic [FW-1:0]      cand_reg, cand_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic               hit_reg, hit_next;
    logic [PADDR_W-1:0] physical_address_reg, physical_address_next;

    logic              pm_we;
    logic [PAGE_W-1:0] pm_waddr, pm_raddr;
    logic [FW-1:0]     pm_wdata, pm_rdata;
    logic              ft_we;
    logic [FW-1:0]     ft_waddr, ft_raddr;
    logic [OWN_W-1:0]  ft_wdata, ft_rdata;

    logic [PAGE_W-1:0] page_calc;
    logic [REM_W-1:0]  rem_fix;
    logic [FCNT_W-1:0] hand_plus;
    logic [FW-1:0]     hand_inc;
    logic [FW-1:0]     res_frame;
    logic              res_hit;

    // page -> frame; entries are trusted only when the frame table agrees
    cpr_ram #(
        .WIDTH(FW),
        .DEPTH(PAGES)
    ) u_page_map (
        .clk  (clk),
        .we   (pm_we),
        .waddr(pm_waddr),
        .wdata(pm_wdata),
        .raddr(pm_raddr),
        .rdata(pm_rdata)
    );

    // frame -> {owner page, use bit}; frames at or above the fill count are empty
    cpr_ram #(
        .WIDTH(OWN_W),
        .DEPTH(FRAMES)
    ) u_frame_table (
        .clk  (clk),
        .we   (ft_we),
        .waddr(ft_waddr),
        .wdata(ft_wdata),
        .raddr(ft_raddr),
        .rdata(ft_rdata)
    );

    // final correction of the reciprocal-based page wrap
    always_comb
    begin
        rem_fix = (rem_reg >= REM_W'(PAGES)) ? rem_reg - REM_W'(PAGES) : rem_reg;
        if (WRAP)
        begin
            page_calc = PAGE_W'(rem_fix);
        end
        else
        begin
            page_calc = PAGE_W'(pn_reg);
        end
    end

    always_comb
    begin
        hand_plus = FCNT_W'(hand_reg) + FCNT_W'(1);
        hand_inc  = (hand_plus == frames_reg) ? '0 : hand_plus[FW-1:0];
    end

    always_comb
    begin
        state_next       = state_reg;
        frames_next      = frames_reg;
        offset_bits_next = offset_bits_reg;
        fill_next        = fill_reg;
        hand_next        = hand_reg;
        done_next        = 1'b0;
        pn_next          = pn_reg;
        off_next         = off_reg;
        prod_next        = prod_reg;
        rem_next         = rem_reg;
        page_next        = page_reg;
        cand_next        = cand_reg;
        res_frame        = cand_reg;
        res_hit          = 1'b0;

        pm_we    = 1'b0;
        pm_waddr = page_reg;
        pm_wdata = cand_reg;
        pm_raddr = page_calc;
        ft_we    = 1'b0;
        ft_waddr = cand_reg;
        ft_wdata = {page_reg, 1'b1};
        ft_raddr = hand_reg;

        unique case (state_reg)
            cpr_pkg::S_IDLE:
            begin
                if (start)
                begin
                    pn_next    = page_number;
                    off_next   = page_offset;
                    state_next = cpr_pkg::S_MOD_MUL;
                end
            end
            cpr_pkg::S_MOD_MUL:
            begin
                prod_next  = PROD_W'(pn_reg) * PROD_W'(RECIP);
                state_next = cpr_pkg::S_MOD_SUB;
            end
            cpr_pkg::S_MOD_SUB:
            begin
                // quotient estimate is exact or one low
                rem_next   = REM_W'(32'(pn_reg) - 32'(prod_reg[PROD_W-1:32]) * 32'(PAGES));
                state_next = cpr_pkg::S_MAP_RD;
            end
            cpr_pkg::S_MAP_RD:
            begin
                page_next  = page_calc;
                state_next = cpr_pkg::S_OWN_RD;
            end
            cpr_pkg::S_OWN_RD:
            begin
                ft_raddr   = pm_rdata;
                cand_next  = pm_rdata;
                state_next = cpr_pkg::S_DECIDE;
            end
            cpr_pkg::S_DECIDE:
            begin
                priority if ((FCNT_W'(cand_reg) < fill_reg) &&
                             (ft_rdata[OWN_W-1:1] == page_reg))
                begin
                    // hit: set the use bit
                    ft_we      = 1'b1;
                    ft_waddr   = cand_reg;
                    res_frame  = cand_reg;
                    res_hit    = 1'b1;
                    done_next  = 1'b1;
                    state_next = cpr_pkg::S_IDLE;
                end
                else if (fill_reg < frames_reg)
                begin
                    // fault with an empty frame left: take the next one in order
                    ft_we      = 1'b1;
                    ft_waddr   = fill_reg[FW-1:0];
                    pm_we      = 1'b1;
                    pm_wdata   = fill_reg[FW-1:0];
                    res_frame  = fill_reg[FW-1:0];
                    fill_next  = fill_reg + FCNT_W'(1);
                    done_next  = 1'b1;
                    state_next = cpr_pkg::S_IDLE;
                end
                else
                begin
                    ft_raddr   = hand_reg;
                    state_next = cpr_pkg::S_SWEEP;
                end
            end
            cpr_pkg::S_SWEEP:
            begin
                hand_next = hand_inc;
                // with a single frame the entry is the victim at once, even with its use bit set
                if (!ft_rdata[0] || (hand_inc == hand_reg))
                begin
                    ft_we      = 1'b1;
                    ft_waddr   = hand_reg;
                    pm_we      = 1'b1;
                    pm_wdata   = hand_reg;
                    res_frame  = hand_reg;
                    done_next  = 1'b1;
                    state_next = cpr_pkg::S_IDLE;
                end
                else
                begin
                    ft_we    = 1'b1;
                    ft_waddr = hand_reg;
                    ft_wdata = {ft_rdata[OWN_W-1:1], 1'b0};
                    ft_raddr = hand_inc;
                end
            end
            default:
            begin
                state_next = cpr_pkg::S_IDLE;
            end
        endcase

        // writing the frame count drops every mapping and rewinds the hand
        if (cfg_write)
        begin
            unique case (cfg_index)
                cpr_pkg::CFG_FRAMES_IN_USE:
                begin
                    if (cfg_data == '0)
                    begin
                        frames_next = FCNT_W'(1);
                    end
                    else if (32'(cfg_data) > 32'(FRAMES))
                    begin
                        frames_next = FCNT_W'(FRAMES);
                    end
                    else
                    begin
                        frames_next = FCNT_W'(cfg_data);
                    end
                    fill_next = '0;
                    hand_next = '0;
                end
                cpr_pkg::CFG_OFFSET_BITS:
                begin
                    if (32'(cfg_data[OB_W-1:0]) > 32'(MAX_OFFSET_BITS))
                    begin
                        offset_bits_next = OB_W'(MAX_OFFSET_BITS);
                    end
                    else
                    begin
                        offset_bits_next = cfg_data[OB_W-1:0];
                    end
                end
                default:
                begin
                    frames_next = frames_reg;
                end
            endcase
        end

        frame_next            = FRAME_W'(res_frame);
        hit_next              = res_hit;
        physical_address_next = PADDR_W'((32'(res_frame) << offset_bits_reg) | 32'(off_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= cpr_pkg::S_IDLE;
            frames_reg      <= FCNT_W'(FRAMES_RST);
            offset_bits_reg <= OB_W'(OB_RST);
            fill_reg        <= '0;
            hand_reg        <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            frames_reg      <= frames_next;
            offset_bits_reg <= offset_bits_next;
            fill_reg        <= fill_next;
            hand_reg        <= hand_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pn_reg   <= pn_next;
        off_reg  <= off_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        page_reg <= page_next;
        cand_reg <= cand_next;
        if (done_next)
        begin
            frame_reg            <= frame_next;
            hit_reg              <= hit_next;
            physical_address_reg <= physical_address_next;
        end
    end

    assign busy             = (state_reg != cpr_pkg::S_IDLE);
    assign done             = done_reg;
    assign frame            = frame_reg;
    assign hit              = hit_reg;
    assign physical_address = physical_address_reg;

    `ASSERT_ALWAYS(a_fill_bounded, fill_reg <= frames_reg, "fill count beyond frame count")
    `ASSERT_ALWAYS(a_hand_bounded, FCNT_W'(hand_reg) < frames_reg, "clock hand out of range")
    `ASSERT_IMPLIES(a_sweep_when_full, state_reg == cpr_pkg::S_SWEEP,
                    fill_reg == frames_reg, "sweep with an empty frame left")
    `ASSERT_IMPLIES(a_done_after_work, done_reg, $past(state_reg) != cpr_pkg::S_IDLE,
                    "result without a request in flight")

endmodule

[hw/rtl/cpr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module cpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
